// ----- rtl/tmdd_pkg.sv -----
// Shared types and constants for the turnout message decoder.
// No dependencies; compiled first.
package tmdd_pkg;

	localparam int unsigned TURNOUT_COUNT     = 2048;
	localparam int unsigned TADDR_W           = $clog2(TURNOUT_COUNT);
	localparam int unsigned PENDING_DEPTH_DEF = 16;

	// message opcodes and bit masks
	localparam logic [7:0] OPC_SWITCH_REQ = 8'hB0;
	localparam logic [7:0] OPC_SW_REP     = 8'hB1;
	localparam logic [7:0] OPC_LACK       = 8'hB4;
	localparam logic [6:0] STATE_ACK_CODE = 7'h3C;
	localparam int unsigned INPUT_BIT_POS  = 6;   // 0x40
	localparam int unsigned CLOSED_BIT_POS = 5;   // 0x20

	localparam logic KIND_MSG     = 1'b0;
	localparam logic KIND_PENDING = 1'b1;

	// known position codes
	localparam logic [1:0] POS_UNKNOWN = 2'd0;
	localparam logic [1:0] POS_THROWN  = 2'd1;
	localparam logic [1:0] POS_CLOSED  = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [7:0]  opcode;
		logic [6:0]  first_data;
		logic [6:0]  second_data;
		logic [11:0] pending_address;
	} msg_word_t;

	typedef struct packed {
		logic [11:0] turnout_address;
		logic        is_closed;
	} evt_word_t;

	// table command from front to back: address minus one and position
	typedef struct packed {
		logic [TADDR_W-1:0] addr;
		logic               closed;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_CHECK
	} back_state_t;

endpackage

// ----- rtl/turnout_message_decoder_dedupe_unit.sv -----
// Turnout message decoder with change filter: front end, command queue, back end.
// Path: queue write, registered table read by the back, then compare and, on a change,
// table write and event register load; an acknowledge first passes the front's ack
// register. The front takes one word a cycle while msg_stall is low; the back takes one
// table command at a time and waits on evt_stall. Reset: the position table is swept to
// unknown, one entry a cycle, msg_stall high throughout; the pending FIFO starts empty.
module turnout_message_decoder_dedupe_unit #(
	parameter int unsigned PENDING_DEPTH = tmdd_pkg::PENDING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_stall,
	input  tmdd_pkg::msg_word_t msg,
	output logic                evt_valid,
	input  logic                evt_stall,
	output tmdd_pkg::evt_word_t evt
);
	import tmdd_pkg::*;

	// front -> queue
	logic    q_push;
	cmd_t    q_wdata;
	// queue -> back
	logic    q_pop;
	cmd_t    q_rdata;
	q_stat_t q_stat;
	// back holds the front off during the table sweep
	logic    clearing;

	// Front decodes each word: switch requests and reports (input bit clear) go to the queue,
	// pending requests fill the FIFO, a state acknowledge pops it and queues the result.
	tmdd_front #(
		.PENDING_DEPTH(PENDING_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg      (msg),
		.clearing (clearing),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	// Short queue so the front keeps taking words while the back waits on evt_stall.
	tmdd_cmd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.stat  (q_stat)
	);

	// Back checks each command against the known-position table and emits an
	// event only on a new or changed position.
	tmdd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rdata  (q_rdata),
		.q_stat   (q_stat),
		.q_pop    (q_pop),
		.clearing (clearing),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt)
	);

endmodule

// ----- rtl/tmdd_front.sv -----
// Front end: accepts words, decodes switch messages, keeps the pending FIFO.
// Depends on tmdd_pkg.
module tmdd_front #(
	parameter int unsigned PENDING_DEPTH = tmdd_pkg::PENDING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_stall,
	input  tmdd_pkg::msg_word_t msg,
	input  logic                clearing,
	input  tmdd_pkg::q_stat_t   q_stat,
	output logic                q_push,
	output tmdd_pkg::cmd_t      q_wdata
);
	import tmdd_pkg::*;

	localparam int unsigned PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);

	logic [TADDR_W-1:0] pend_mem [PENDING_DEPTH];
	logic [PW-1:0]      head_q, tail_q;
	logic [CW-1:0]      count_q;
	logic               ack_pend_q;
	logic [TADDR_W-1:0] ack_addr_q;
	logic               ack_closed_q;

	logic               acc, is_sw, is_ack, is_push, addr_ok;
	logic [11:0]        paddr_m1;
	cmd_t               dec_cmd;

	assign msg_stall = clearing | ack_pend_q | q_stat.full;
	assign acc       = msg_valid & ~msg_stall;

	assign is_sw = (msg.kind == KIND_MSG) &&
		((msg.opcode == OPC_SWITCH_REQ) ||
		 ((msg.opcode == OPC_SW_REP) && !msg.second_data[INPUT_BIT_POS]));
	assign is_ack = (msg.kind == KIND_MSG) && (msg.opcode == OPC_LACK) &&
		(msg.first_data == STATE_ACK_CODE) && (count_q != '0);
	assign addr_ok  = (msg.pending_address != 12'd0) &&
		(msg.pending_address <= 12'(TURNOUT_COUNT));
	assign is_push  = (msg.kind == KIND_PENDING) && addr_ok &&
		(count_q < CW'(PENDING_DEPTH));
	assign paddr_m1 = msg.pending_address - 12'd1;

	assign dec_cmd.addr   = {msg.second_data[3:0], msg.first_data};
	assign dec_cmd.closed = msg.second_data[CLOSED_BIT_POS];

	// ack result goes out the cycle after the FIFO read
	assign q_push = (acc & is_sw) | ack_pend_q;
	always_comb begin
		if (ack_pend_q) begin
			q_wdata.addr   = ack_addr_q;
			q_wdata.closed = ack_closed_q;
		end else begin
			q_wdata = dec_cmd;
		end
	end

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		wrap_inc = (p == PW'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (acc && is_push) begin
			pend_mem[tail_q] <= paddr_m1[TADDR_W-1:0];
		end
		if (acc && is_ack) begin
			ack_addr_q   <= pend_mem[head_q];
			ack_closed_q <= msg.second_data[CLOSED_BIT_POS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			ack_pend_q <= 1'b0;
		end else begin
			ack_pend_q <= acc & is_ack;
			if (acc && is_push) begin
				tail_q  <= wrap_inc(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (acc && is_ack) begin
				head_q  <= wrap_inc(head_q);
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/tmdd_cmd_queue.sv -----
// Two-entry command queue between front and back ends.
// Depends on tmdd_pkg.
module tmdd_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tmdd_pkg::cmd_t    wdata,
	input  logic              pop,
	output tmdd_pkg::cmd_t    rdata,
	output tmdd_pkg::q_stat_t stat
);
	import tmdd_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign rdata      = ent_q[rd_q];
	assign stat.empty = (cnt_q == 2'd0);
	assign stat.full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/tmdd_back.sv -----
// Back end: known-position table, change filter and event output register.
// Depends on tmdd_pkg.
module tmdd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tmdd_pkg::cmd_t      q_rdata,
	input  tmdd_pkg::q_stat_t   q_stat,
	output logic                q_pop,
	output logic                clearing,
	output logic                evt_valid,
	input  logic                evt_stall,
	output tmdd_pkg::evt_word_t evt
);
	import tmdd_pkg::*;

	logic [1:0]         pos_mem [TURNOUT_COUNT];
	logic [1:0]         rd_data_q;
	cmd_t               cmd_q;
	logic [TADDR_W-1:0] clr_q;
	back_state_t        state_q, state_d;

	logic               mem_we, load_out, out_free, changed;
	logic [TADDR_W-1:0] mem_waddr;
	logic [1:0]         mem_wdata, new_code;

	assign out_free = ~evt_valid | ~evt_stall;
	assign new_code = cmd_q.closed ? POS_CLOSED : POS_THROWN;
	assign changed  = (rd_data_q != new_code);

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cmd_q.addr;
		mem_wdata = new_code;
		load_out  = 1'b0;
		clearing  = 1'b0;
		case (state_q)
			B_CLEAR: begin
				clearing  = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = POS_UNKNOWN;
				if (clr_q == '1) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_stat.empty) begin
					q_pop   = 1'b1;
					state_d = B_CHECK;
				end
			end
			B_CHECK: begin
				if (!changed) begin
					state_d = B_IDLE;
				end else if (out_free) begin
					mem_we   = 1'b1;
					load_out = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pos_mem[mem_waddr] <= mem_wdata;
		end
		if (q_pop) begin
			rd_data_q <= pos_mem[q_rdata.addr];
			cmd_q     <= q_rdata;
		end
		if (load_out) begin
			evt.turnout_address <= {1'b0, cmd_q.addr} + 12'd1;
			evt.is_closed       <= cmd_q.closed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_q     <= '0;
			evt_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				evt_valid <= 1'b1;
			end else if (!evt_stall) begin
				evt_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- tb/tb_turnout_message_decoder_dedupe_unit.sv -----
// Testbench for turnout_message_decoder_dedupe_unit: directed table, then random words.
// A predictor tracks known positions and pending requests and checks every event.
// Depends on rtl/tmdd_pkg.sv and rtl/turnout_message_decoder_dedupe_unit.sv.
`timescale 1ns / 100ps

module tb_turnout_message_decoder_dedupe_unit;
	import tmdd_pkg::*;

	// watchdog: cycles with no word accepted on either side; covers the
	// table sweep after reset plus the longest gaps and stalls
	localparam int IDLE_LIMIT   = 6000;
	localparam int RANDOM_WORDS = 1200;
	localparam int BURST_LEN    = 18;   // two more than the FIFO holds
	localparam int DRAIN_CYCLES = 16;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      msg_valid;
	logic      msg_stall;
	msg_word_t msg;
	logic      evt_valid;
	logic      evt_stall;
	evt_word_t evt;

	typedef struct {
		msg_word_t w;
		logic      typed;   // expectation written into the table by hand
		logic      hit;
		evt_word_t e;
	} stim_row_t;

	// predictor state
	logic [1:0]          position_table [TURNOUT_COUNT];
	logic [TADDR_W-1:0]  ack_wait_q [$];
	evt_word_t           expected_events [$];
	stim_row_t           directed_rows [$];

	bit no_idle = 1'b0;
	int errors = 0;
	int idle_cycles = 0;
	int words_sent = 0;
	int events_seen = 0;
	int pushes_dropped = 0;
	int pushes_rejected = 0;
	int acks_popped = 0;

	turnout_message_decoder_dedupe_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg      (msg),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// record a position; an event only when it is new or changed
	function automatic bit record_position(input logic [TADDR_W-1:0] a, input logic closed,
			output evt_word_t e);
		logic [1:0] code;
		code = closed ? POS_CLOSED : POS_THROWN;
		e = '0;
		if (position_table[a] == code)
			return 1'b0;
		position_table[a] = code;
		e.turnout_address = {1'b0, a} + 12'd1;
		e.is_closed = closed;
		return 1'b1;
	endfunction

	function automatic bit decode_turnout_word(input msg_word_t w, output evt_word_t e);
		logic [TADDR_W-1:0] a;
		logic               closed;
		e = '0;
		closed = w.second_data[CLOSED_BIT_POS];
		if (w.kind == KIND_PENDING) begin
			// message fields are don't-care here
			if (w.pending_address < 12'd1 || w.pending_address > TURNOUT_COUNT)
				pushes_rejected++;
			else if (ack_wait_q.size() >= PENDING_DEPTH_DEF)
				pushes_dropped++;
			else
				ack_wait_q.push_back(TADDR_W'(w.pending_address - 12'd1));
			return 1'b0;
		end
		if (w.opcode == OPC_SWITCH_REQ ||
				(w.opcode == OPC_SW_REP && !w.second_data[INPUT_BIT_POS]))
			return record_position({w.second_data[3:0], w.first_data}, closed, e);
		if (w.opcode == OPC_LACK && w.first_data == STATE_ACK_CODE &&
				ack_wait_q.size() != 0) begin
			a = ack_wait_q.pop_front();
			acks_popped++;
			return record_position(a, closed, e);
		end
		// sensor reports, other ack codes, other opcodes: nothing
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	function automatic msg_word_t make_word(input logic kind, input logic [7:0] opc,
			input logic [6:0] d1, input logic [6:0] d2, input logic [11:0] paddr);
		msg_word_t w;
		w.kind = kind;
		w.opcode = opc;
		w.first_data = d1;
		w.second_data = d2;
		w.pending_address = paddr;
		return w;
	endfunction

	function automatic void add_row(input msg_word_t w, input int typed, input int hit,
			input logic [11:0] addr, input int closed);
		stim_row_t r;
		r.w = w;
		r.typed = (typed != 0);
		r.hit = (hit != 0);
		r.e.turnout_address = addr;
		r.e.is_closed = (closed != 0);
		directed_rows.push_back(r);
	endfunction

	// address minus one; mostly a small pool so positions repeat and flip
	function automatic logic [TADDR_W-1:0] pick_turnout();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return TADDR_W'($urandom_range(0, 31));
		if (r < 6)
			return TADDR_W'(TURNOUT_COUNT - 32 + $urandom_range(0, 31));
		return TADDR_W'($urandom);
	endfunction

	function automatic msg_word_t random_word();
		msg_word_t          w;
		logic [TADDR_W-1:0] a;
		int                 r;
		w = make_word(KIND_MSG, 8'($urandom), 7'($urandom), 7'($urandom), 12'($urandom));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			// well-formed switch request or report
			a = pick_turnout();
			w.opcode = $urandom_range(0, 1) ? OPC_SW_REP : OPC_SWITCH_REQ;
			w.first_data = a[6:0];
			w.second_data[3:0] = a[10:7];
			if (w.opcode == OPC_SW_REP)
				w.second_data[INPUT_BIT_POS] = ($urandom_range(0, 9) == 0);
		end else if (r < 65) begin
			w.kind = KIND_PENDING;
			w.pending_address = {1'b0, pick_turnout()} + 12'd1;
		end else if (r < 85) begin
			w.opcode = OPC_LACK;
			w.first_data = STATE_ACK_CODE;
		end else if (r < 90) begin
			// opcode already random
		end else if (r < 94) begin
			w.opcode = OPC_LACK;   // random ack code
		end else if (r < 97) begin
			w.kind = KIND_PENDING;
			w.pending_address = $urandom_range(0, 3) == 0 ? 12'd0
				: 12'($urandom_range(TURNOUT_COUNT + 1, 4095));
		end else begin
			w.kind = 1'($urandom);
		end
		return w;
	endfunction

	// most gaps short, a few long
	function automatic int idle_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// drive one word at the falling edge, hold it until accepted, then predict
	task automatic send_word(input msg_word_t w, input logic typed, input logic typed_hit,
			input evt_word_t typed_e);
		int        gap;
		bit        hit;
		evt_word_t e;
		gap = idle_gap();
		if (gap > 0) begin
			@(negedge clk);
			msg_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		msg <= w;
		msg_valid <= 1'b1;
		do @(posedge clk); while (msg_stall);
		hit = decode_turnout_word(w, e);
		if (typed) begin
			hit = typed_hit;
			e = typed_e;
		end
		if (hit)
			expected_events.push_back(e);
		words_sent++;
	endtask

	// hold-off: nothing new until every predicted event has come out
	task automatic wait_for_drain();
		@(negedge clk);
		msg_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Event side: random stall, check in order
	// ---------------------------------------------------------------

	initial begin
		int n;
		evt_stall = 1'b0;
		forever begin
			n = $urandom_range(1, 20);
			repeat (n) @(negedge clk) evt_stall <= 1'b0;
			n = idle_gap();
			repeat (n) @(negedge clk) evt_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		evt_word_t exp_e;
		if (arst_n && evt_valid && !evt_stall) begin
			events_seen++;
			if (expected_events.size() == 0) begin
				$error("unexpected event: turnout_address %0d is_closed %0d",
					evt.turnout_address, evt.is_closed);
				errors++;
			end else begin
				exp_e = expected_events.pop_front();
				if (evt.turnout_address !== exp_e.turnout_address) begin
					$error("turnout_address: expected %0d, got %0d",
						exp_e.turnout_address, evt.turnout_address);
					errors++;
				end
				if (evt.is_closed !== exp_e.is_closed) begin
					$error("is_closed: expected %0d, got %0d",
						exp_e.is_closed, evt.is_closed);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((msg_valid && !msg_stall) || (evt_valid && !evt_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------

	initial begin
		evt_word_t none;
		int        j;
		none = '0;
		msg_valid = 1'b0;
		msg = '0;
		arst_n = 1'b0;
		foreach (position_table[k])
			position_table[k] = POS_UNKNOWN;

		// Directed table. Typed rows start from all-unknown positions and an
		// empty request FIFO; the rest rely on the predictor.
		// first sighting closed, then the same again (filtered), then thrown
		add_row(make_word(KIND_MSG, OPC_SWITCH_REQ, 7'h00, 7'h20, 12'd0), 1, 1, 12'd1, 1);
		add_row(make_word(KIND_MSG, OPC_SWITCH_REQ, 7'h00, 7'h20, 12'd0), 1, 0, 12'd0, 0);
		add_row(make_word(KIND_MSG, OPC_SW_REP, 7'h00, 7'h00, 12'd0), 1, 1, 12'd1, 0);
		// top address
		add_row(make_word(KIND_MSG, OPC_SWITCH_REQ, 7'h7F, 7'h2F, 12'hFFF),
			1, 1, 12'd2048, 1);
		// sensor report ignored
		add_row(make_word(KIND_MSG, OPC_SW_REP, 7'h7F, 7'h4F, 12'd0), 1, 0, 12'd0, 0);
		// request with the input bit still counts
		add_row(make_word(KIND_MSG, OPC_SWITCH_REQ, 7'h7F, 7'h4F, 12'd0),
			1, 1, 12'd2048, 0);
		// bit 4 of the third byte is not part of the address
		add_row(make_word(KIND_MSG, OPC_SWITCH_REQ, 7'h55, 7'h1A, 12'h555), 0, 0, 12'd0, 0);
		// unknown opcodes at both ends
		add_row(make_word(KIND_MSG, 8'h00, 7'h7F, 7'h7F, 12'hFFF), 1, 0, 12'd0, 0);
		add_row(make_word(KIND_MSG, 8'hFF, 7'h7F, 7'h7F, 12'hFFF), 1, 0, 12'd0, 0);
		// acknowledge with nothing pending
		add_row(make_word(KIND_MSG, OPC_LACK, STATE_ACK_CODE, 7'h20, 12'd0), 1, 0, 12'd0, 0);
		// out-of-range pending requests are dropped, 2048 and 1 queued; message fields ignored
		add_row(make_word(KIND_PENDING, OPC_SWITCH_REQ, 7'h00, 7'h20, 12'd0), 1, 0, 12'd0, 0);
		add_row(make_word(KIND_PENDING, OPC_SWITCH_REQ, 7'h00, 7'h20, 12'hFFF),
			1, 0, 12'd0, 0);
		add_row(make_word(KIND_PENDING, OPC_SW_REP, 7'h7F, 7'h7F, 12'd2049), 1, 0, 12'd0, 0);
		add_row(make_word(KIND_PENDING, OPC_SWITCH_REQ, 7'h00, 7'h20, 12'd2048),
			1, 0, 12'd0, 0);
		add_row(make_word(KIND_PENDING, 8'h00, 7'h00, 7'h00, 12'd1), 1, 0, 12'd0, 0);
		// wrong ack code leaves the FIFO alone
		add_row(make_word(KIND_MSG, OPC_LACK, STATE_ACK_CODE ^ 7'h01, 7'h20, 12'd0),
			1, 0, 12'd0, 0);
		// pops 2048: already thrown, filtered
		add_row(make_word(KIND_MSG, OPC_LACK, STATE_ACK_CODE, 7'h00, 12'd0), 1, 0, 12'd0, 0);
		// pops 1: thrown -> closed
		add_row(make_word(KIND_MSG, OPC_LACK, STATE_ACK_CODE, 7'h20, 12'd0), 1, 1, 12'd1, 1);
		add_row(make_word(KIND_MSG, OPC_LACK, STATE_ACK_CODE, 7'h7F, 12'hFFF), 1, 0, 12'd0, 0);
		add_row(make_word(KIND_MSG, OPC_SW_REP, 7'h00, 7'h3F, 12'd0), 0, 0, 12'd0, 0);
		add_row(make_word(KIND_MSG, OPC_SWITCH_REQ, 7'h2A, 7'h05, 12'd0), 0, 0, 12'd0, 0);
		add_row(make_word(KIND_MSG, OPC_LACK, 7'h7F, 7'h7F, 12'd0), 1, 0, 12'd0, 0);
		// ack takes only the closed bit from a third byte of all ones
		add_row(make_word(KIND_PENDING, 8'hFF, 7'h7F, 7'h7F, 12'd2048), 1, 0, 12'd0, 0);
		add_row(make_word(KIND_MSG, OPC_LACK, STATE_ACK_CODE, 7'h7F, 12'd0),
			1, 1, 12'd2048, 1);

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (directed_rows[k])
			send_word(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].hit,
				directed_rows[k].e);
		wait_for_drain();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			no_idle = (i >= 500 && i < 700);
			if (i % 200 == 100) begin
				// fill the request FIFO past full, then empty it with acks
				wait_for_drain();
				for (j = 0; j < BURST_LEN; j++)
					send_word(make_word(KIND_PENDING, 8'($urandom), 7'($urandom),
						7'($urandom), {1'b0, pick_turnout()} + 12'd1),
						1'b0, 1'b0, none);
				for (j = 0; j < BURST_LEN; j++)
					send_word(make_word(KIND_MSG, OPC_LACK, STATE_ACK_CODE,
						7'($urandom), 12'($urandom)), 1'b0, 1'b0, none);
			end
			send_word(random_word(), 1'b0, 1'b0, none);
		end

		@(negedge clk) msg_valid <= 1'b0;
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words sent, %0d events checked, %0d acks matched a request",
			words_sent, events_seen, acks_popped);
		$display("pending requests dropped: %0d on full FIFO, %0d out of range",
			pushes_dropped, pushes_rejected);
		if (errors == 0 && expected_events.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d events never seen", errors, expected_events.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
